@@ src/ots_pkg.sv @@
package ots_pkg;

  // Field widths of the item and result payloads
  localparam int OP_W    = 2;
  localparam int DELAY_W = 16;
  localparam int SLOT_W  = 5;
  localparam int KIND_W  = 2;
  localparam int REG_W   = 11;
  localparam int TIME_W  = 27;
  localparam int DEC_W   = 21;
  localparam int CFG_IDX_W = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ARMED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP  = 1'b1;

  localparam logic [REG_W-1:0] CLOCK_RATE_RESET = 11'd128;
  localparam logic [REG_W-1:0] TICK_STEP_RESET  = 11'd1;

  // Clock ticks are kept in units of 1/1000 tick
  localparam logic [DEC_W-1:0] TICK_SCALE = 21'd1000;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [DELAY_W-1:0] delay_ms;
    logic [SLOT_W-1:0]  slot_id;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_t;

  // Token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic valid;
    logic is_arm;
    logic pending;
  } tok_t;

  // Broadcast controls shared by every cell
  typedef struct packed {
    logic               cancel;
    logic [SLOT_W-1:0]  slot_id;
    logic [TIME_W-1:0]  arm_time;
    logic [DEC_W-1:0]   dec;
  } cell_ctl_t;

endpackage

@@ src/ots_cell.sv @@
module ots_cell #(
  parameter int Idx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ots_pkg::cell_ctl_t ctl_i,
  input  ots_pkg::tok_t     tok_i,
  output ots_pkg::tok_t     tok_o,
  output logic              hit_o
);

  logic                          busy_q, busy_d;
  logic [ots_pkg::TIME_W-1:0]    time_q, time_d;
  logic [ots_pkg::TIME_W-1:0]    dec_ext;
  logic [ots_pkg::TIME_W-1:0]    time_sub;
  logic                          expired;
  logic                          claim;
  logic                          fire;
  logic                          cancel_me;
  ots_pkg::tok_t                 tok_q, tok_d;

  // Saturating decrement and expiry test for this slot
  assign dec_ext  = ots_pkg::TIME_W'(ctl_i.dec);
  assign time_sub = (time_q > dec_ext) ? (time_q - dec_ext) : '0;
  assign expired  = time_sub < dec_ext;

  assign cancel_me = ctl_i.cancel && (int'(ctl_i.slot_id) == Idx);
  assign claim = tok_i.valid && tok_i.is_arm && tok_i.pending && !busy_q;
  assign fire  = tok_i.valid && !tok_i.is_arm && busy_q && expired;

  // Update slot state as the token passes, clear on cancel
  always_comb begin
    busy_d = busy_q;
    time_d = time_q;
    tok_d  = tok_i;
    if (cancel_me) begin
      busy_d = 1'b0;
    end
    if (claim) begin
      busy_d        = 1'b1;
      time_d        = ctl_i.arm_time;
      tok_d.pending = 1'b0;
    end
    if (tok_i.valid && !tok_i.is_arm && busy_q) begin
      time_d = time_sub;
      if (expired) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      busy_q <= busy_d;
      tok_q  <= tok_d;
    end
  end

  // Remaining time needs no reset
  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

  assign tok_o = tok_q;
  assign hit_o = claim || fire;

endmodule

@@ src/one_shot_timer_bank.sv @@
// Bank of SLOT_COUNT one-shot timers.
// Input: an item (operation, delay_ms, slot_id) is taken when start is high
// and busy is low. Arm claims the lowest free slot and loads delay_ms times
// clock_rate; cancel frees slot_id at once; tick takes tick_step*1000 off every
// busy slot and frees each slot left below one step.
// Results: result_valid_o marks result_o for one cycle; there is no stall.
// Arm gives exactly one result (armed or full). Tick gives one result per
// expired slot in ascending slot order, last set on the final one; none if
// nothing expires. Cancel gives none.
// Timing: a token walks the row of cells one cell per clock, so busy stays high
// while the token of an arm or tick is in the row, and the next item can be
// taken once it has left; an arm result for slot i is registered when the
// token reaches cell i. A cancel launches no token.
// Config: cfg_we_i writes clock_rate (index 0) or tick_step (index 1); the user
// must write them only while busy is low, which the block does not enforce.
// Reset: all slots free, clock_rate 128, tick_step 1.
module one_shot_timer_bank #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  ots_pkg::in_item_t               item_i,
  output logic                            result_valid_o,
  output ots_pkg::result_t                result_o,
  input  logic                            cfg_we_i,
  input  logic [ots_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ots_pkg::REG_W-1:0]       cfg_data_i
);

  localparam int SlotW = ots_pkg::SLOT_W;

  logic [ots_pkg::REG_W-1:0]  clock_rate_q, tick_step_q;
  logic [ots_pkg::TIME_W-1:0] arm_time_q;
  logic [ots_pkg::DEC_W-1:0]  dec_q;
  logic                       op_arm_q;
  ots_pkg::tok_t              tok0_q, tok0_d;
  ots_pkg::tok_t              tok_chain [SLOT_COUNT+1];
  ots_pkg::tok_t              tok_exit;
  logic [SLOT_COUNT-1:0]      hit_vec;
  logic [SLOT_COUNT-1:0]      tok_valid_vec;
  logic                       any_hit;
  logic [SlotW-1:0]           hit_slot;
  ots_pkg::cell_ctl_t         ctl;
  logic                       accept;
  logic                       hold_valid_q, hold_valid_d;
  logic [SlotW-1:0]           hold_slot_q, hold_slot_d;
  logic                       res_valid_q, res_valid_d;
  ots_pkg::result_t           res_q, res_d;

  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_rate_q <= ots_pkg::CLOCK_RATE_RESET;
      tick_step_q  <= ots_pkg::TICK_STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ots_pkg::REG_CLOCK_RATE: clock_rate_q <= cfg_data_i;
        ots_pkg::REG_TICK_STEP:  tick_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Launch the token into the cell row
  always_comb begin
    tok0_d         = '0;
    tok0_d.valid   = accept && ((item_i.operation == ots_pkg::OP_ARM) ||
                                (item_i.operation == ots_pkg::OP_TICK));
    tok0_d.is_arm  = item_i.operation == ots_pkg::OP_ARM;
    tok0_d.pending = item_i.operation == ots_pkg::OP_ARM;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q <= tok0_d;
    end
  end

  // Scale delay and step once per item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      arm_time_q <= ots_pkg::TIME_W'(item_i.delay_ms) * ots_pkg::TIME_W'(clock_rate_q);
      dec_q      <= ots_pkg::DEC_W'(tick_step_q) * ots_pkg::TICK_SCALE;
      op_arm_q   <= item_i.operation == ots_pkg::OP_ARM;
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.cancel   = accept && (item_i.operation == ots_pkg::OP_CANCEL);
    ctl.slot_id  = item_i.slot_id;
    ctl.arm_time = arm_time_q;
    ctl.dec      = dec_q;
  end

  // Row of timer cells
  assign tok_chain[0] = tok0_q;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    ots_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .tok_i (tok_chain[g]),
      .tok_o (tok_chain[g+1]),
      .hit_o (hit_vec[g])
    );
    assign tok_valid_vec[g] = tok_chain[g+1].valid;
  end

  assign tok_exit = tok_chain[SLOT_COUNT];
  assign any_hit  = |hit_vec;

  // Slot number of the single hitting cell
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit_vec[i]) begin
        hit_slot = hit_slot | SlotW'(i);
      end
    end
  end

  // Hold one expiration back so the final one can carry last
  always_comb begin
    res_valid_d  = 1'b0;
    res_d        = '0;
    hold_valid_d = hold_valid_q;
    hold_slot_d  = hold_slot_q;
    if (any_hit && op_arm_q) begin
      res_valid_d       = 1'b1;
      res_d.result_kind = ots_pkg::KIND_ARMED;
      res_d.slot        = hit_slot;
      res_d.last        = 1'b1;
    end else if (any_hit) begin
      res_valid_d       = hold_valid_q;
      res_d.result_kind = ots_pkg::KIND_EXPIRED;
      res_d.slot        = hold_slot_q;
      res_d.last        = 1'b0;
      hold_valid_d      = 1'b1;
      hold_slot_d       = hit_slot;
    end else if (tok_exit.valid && tok_exit.is_arm && tok_exit.pending) begin
      res_valid_d       = 1'b1;
      res_d.result_kind = ots_pkg::KIND_FULL;
      res_d.slot        = '0;
      res_d.last        = 1'b1;
    end else if (tok_exit.valid && !tok_exit.is_arm && hold_valid_q) begin
      res_valid_d       = 1'b1;
      res_d.result_kind = ots_pkg::KIND_EXPIRED;
      res_d.slot        = hold_slot_q;
      res_d.last        = 1'b1;
      hold_valid_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_slot_q <= hold_slot_d;
    res_q       <= res_d;
  end

  assign busy           = tok0_q.valid || (|tok_valid_vec) || hold_valid_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one cell hit in a cycle");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_valid_vec, tok0_q.valid}))
    else $error("more than one token in the cell row");

  a_busy_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tok0_d.valid) |=> busy)
    else $error("busy low after a walking item was taken");

  a_arm_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.result_kind != ots_pkg::KIND_EXPIRED)) |-> result_o.last)
    else $error("arm result without last");
`endif

endmodule
